// ===== rtl/bwts_pkg.sv =====
// ----------------------------------------------------------------------------
// bwts_pkg
// Shared types and constants for the bilinear repeat-wrap texture sampler.
// ----------------------------------------------------------------------------
package bwts_pkg;

  // Texture store geometry
  localparam int MAX_TEXELS = 65536;
  localparam int CHANNELS   = 4;
  localparam int ADDR_W     = $clog2(MAX_TEXELS);
  localparam int TEXEL_W    = 8 * CHANNELS;

  // Coordinate and size widths
  localparam int SIZE_W  = 9;
  localparam int IDX_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int ROW_W   = 2 * IDX_W;
  localparam int Q_W     = FRAC_W + SIZE_W;
  localparam int WGT_W   = 17;
  localparam int ACC_W   = 24;
  localparam int SIZE_MAX = 256;

  // Stream payload widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = TEXEL_W;

  // Request kinds carried on the input tuser bit
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Neighbor texel select: bit 1 picks the lower row, bit 0 the right column
  typedef enum logic [1:0] {
    NBR_00 = 2'd0,
    NBR_01 = 2'd1,
    NBR_10 = 2'd2,
    NBR_11 = 2'd3
  } nbr_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_LOCATE,
    ST_ROWS,
    ST_READ0,
    ST_READ1,
    ST_READ2,
    ST_READ3,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic locate;
    logic rows;
    logic wr;
    logic rd;
    nbr_t nbr;
    logic acc_clr;
    logic acc_en;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_block;
  } dp_stat_t;

endpackage

// ===== rtl/bwts_ram.sv =====
// ----------------------------------------------------------------------------
// bwts_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bwts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bwts_ctrl.sv =====
// ----------------------------------------------------------------------------
// bwts_ctrl
// Sequencer for texel writes and bilinear samples.
// ----------------------------------------------------------------------------
module bwts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  input  bwts_pkg::dp_stat_t stat,
  output bwts_pkg::dp_cmd_t  cmd
);

  import bwts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == CMD_SAMPLE) ? ST_LOCATE : ST_WRITE;
        end
      end
      ST_WRITE:  state_nxt = ST_IDLE;
      ST_LOCATE: state_nxt = ST_ROWS;
      ST_ROWS:   state_nxt = ST_READ0;
      ST_READ0:  state_nxt = ST_READ1;
      ST_READ1:  state_nxt = ST_READ2;
      ST_READ2:  state_nxt = ST_READ3;
      ST_READ3:  state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!stat.out_block) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.nbr  = NBR_00;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_WRITE:  cmd.wr     = 1'b1;
      ST_LOCATE: cmd.locate = 1'b1;
      ST_ROWS:   cmd.rows   = 1'b1;
      ST_READ0: begin
        cmd.rd      = 1'b1;
        cmd.nbr     = NBR_00;
        cmd.acc_clr = 1'b1;
      end
      ST_READ1: begin
        cmd.rd     = 1'b1;
        cmd.nbr    = NBR_01;
        cmd.acc_en = 1'b1;
      end
      ST_READ2: begin
        cmd.rd     = 1'b1;
        cmd.nbr    = NBR_10;
        cmd.acc_en = 1'b1;
      end
      ST_READ3: begin
        cmd.rd     = 1'b1;
        cmd.nbr    = NBR_11;
        cmd.acc_en = 1'b1;
      end
      ST_DRAIN:  cmd.acc_en   = 1'b1;
      ST_DONE:   cmd.out_load = !stat.out_block;
      default:   cmd          = '0;
    endcase
  end

endmodule

// ===== rtl/bwts_dp.sv =====
// ----------------------------------------------------------------------------
// bwts_dp
// Datapath: coordinate wrap, neighbor addressing, texel store and blend.
// ----------------------------------------------------------------------------
module bwts_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bwts_pkg::dp_cmd_t                    cmd,
  output bwts_pkg::dp_stat_t                   stat,
  input  logic [bwts_pkg::SIZE_W-1:0]          tex_width,
  input  logic [bwts_pkg::SIZE_W-1:0]          tex_height,
  input  logic [bwts_pkg::IN_DATA_W-1:0]       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bwts_pkg::OUT_DATA_W-1:0]      out_data
);

  import bwts_pkg::*;

  // Captured request fields
  logic [FRAC_W-1:0]  u_f_r;
  logic [FRAC_W-1:0]  v_f_r;
  logic [IDX_W-1:0]   tx_r;
  logic [IDX_W-1:0]   ty_r;
  logic [TEXEL_W-1:0] wdata_r;

  // Neighbor indices and weights
  logic [IDX_W-1:0]  x0_r, x1_r, y0_r, y1_r;
  logic [IDX_W-1:0]  wx_r, wy_r;
  logic [ROW_W-1:0]  row0_r, row1_r;
  logic [WGT_W-1:0]  wt_r [CHANNELS];

  // Read tracking and accumulators
  nbr_t              nbr_d_r;
  logic              rzero_r;
  logic [ACC_W-1:0]  acc_r [CHANNELS];
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_valid_r;

  // Capture the payload fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      u_f_r   <= in_data[FRAC_W-1:0];
      v_f_r   <= in_data[32 +: FRAC_W];
      tx_r    <= in_data[64 +: IDX_W];
      ty_r    <= in_data[72 +: IDX_W];
      wdata_r <= in_data[80 +: TEXEL_W];
    end
  end

  // Scale each fraction by the size and offset by half a texel
  logic [Q_W-1:0]    qx, qy;
  logic [SIZE_W-1:0] hx, hy;
  logic [SIZE_W-1:0] x0_c, x1_c, y0_c, y1_c;

  always_comb begin
    qx = Q_W'({{SIZE_W{1'b0}}, u_f_r} * {{FRAC_W{1'b0}}, tex_width})
       + Q_W'(1 << (FRAC_W - 1));
    qy = Q_W'({{SIZE_W{1'b0}}, v_f_r} * {{FRAC_W{1'b0}}, tex_height})
       + Q_W'(1 << (FRAC_W - 1));
    hx = qx[Q_W-1:FRAC_W];
    hy = qy[Q_W-1:FRAC_W];
    x0_c = (hx == '0) ? tex_width - 1'b1 : hx - 1'b1;
    x1_c = (hx >= tex_width) ? '0 : hx;
    y0_c = (hy == '0) ? tex_height - 1'b1 : hy - 1'b1;
    y1_c = (hy >= tex_height) ? '0 : hy;
  end

  always_ff @(posedge clk) begin
    if (cmd.locate) begin
      x0_r <= x0_c[IDX_W-1:0];
      x1_r <= x1_c[IDX_W-1:0];
      y0_r <= y0_c[IDX_W-1:0];
      y1_r <= y1_c[IDX_W-1:0];
      wx_r <= qx[FRAC_W-1:FRAC_W-IDX_W];
      wy_r <= qy[FRAC_W-1:FRAC_W-IDX_W];
    end
  end

  // Row offsets and the four blend weights
  logic [SIZE_W-1:0] iwx, iwy;
  logic [WGT_W-1:0]  wx_e, wy_e, iwx_e, iwy_e;

  assign iwx = SIZE_W'(SIZE_MAX) - {1'b0, wx_r};
  assign iwy = SIZE_W'(SIZE_MAX) - {1'b0, wy_r};

  assign wx_e  = {{(WGT_W - IDX_W){1'b0}}, wx_r};
  assign wy_e  = {{(WGT_W - IDX_W){1'b0}}, wy_r};
  assign iwx_e = {{(WGT_W - SIZE_W){1'b0}}, iwx};
  assign iwy_e = {{(WGT_W - SIZE_W){1'b0}}, iwy};

  always_ff @(posedge clk) begin
    if (cmd.rows) begin
      row0_r <= ROW_W'({{SIZE_W{1'b0}}, y0_r} * {{IDX_W{1'b0}}, tex_width});
      row1_r <= ROW_W'({{SIZE_W{1'b0}}, y1_r} * {{IDX_W{1'b0}}, tex_width});
      wt_r[NBR_00] <= iwx_e * iwy_e;
      wt_r[NBR_01] <= wx_e * iwy_e;
      wt_r[NBR_10] <= iwx_e * wy_e;
      wt_r[NBR_11] <= wx_e * wy_e;
    end
  end

  // Read address of the selected neighbor and write address of the captured texel
  logic [ROW_W:0]   rsum;
  logic [ROW_W:0]   wsum;
  logic             rd_ok, wr_ok;
  logic [ROW_W-1:0] wrow;

  always_comb begin
    rsum  = {1'b0, cmd.nbr[1] ? row1_r : row0_r}
          + {{(ROW_W + 1 - IDX_W){1'b0}}, cmd.nbr[0] ? x1_r : x0_r};
    rd_ok = (rsum < (ROW_W + 1)'(MAX_TEXELS));
    wrow  = ROW_W'({{SIZE_W{1'b0}}, ty_r} * {{IDX_W{1'b0}}, tex_width});
    wsum  = {1'b0, wrow} + {{(ROW_W + 1 - IDX_W){1'b0}}, tx_r};
    wr_ok = ({1'b0, tx_r} < tex_width) && ({1'b0, ty_r} < tex_height)
          && (wsum < (ROW_W + 1)'(MAX_TEXELS));
  end

  // Texel store access
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [TEXEL_W-1:0] ram_rdata;

  assign ram_we   = cmd.wr && wr_ok;
  assign ram_en   = ram_we || (cmd.rd && rd_ok);
  assign ram_addr = cmd.wr ? ADDR_W'(wsum) : ADDR_W'(rsum);

  bwts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (MAX_TEXELS)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wdata_r),
    .rdata (ram_rdata)
  );

  // Track which neighbor the read data belongs to
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      nbr_d_r <= cmd.nbr;
      rzero_r <= !rd_ok;
    end
  end

  // Accumulate weighted channels, seeded with the rounding offset
  logic [TEXEL_W-1:0] texel;

  assign texel = rzero_r ? '0 : ram_rdata;

  always_ff @(posedge clk) begin
    for (int k = 0; k < CHANNELS; k++) begin
      if (cmd.acc_clr) begin
        acc_r[k] <= ACC_W'(1 << (2 * IDX_W - 1));
      end else if (cmd.acc_en) begin
        acc_r[k] <= acc_r[k]
                  + ({{(ACC_W - 8){1'b0}}, texel[8*k +: 8]}
                     * {{(ACC_W - WGT_W){1'b0}}, wt_r[nbr_d_r]});
      end
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < CHANNELS; k++) begin
        out_data_r[8*k +: 8] <= acc_r[k][ACC_W-1 -: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_block = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

// ===== rtl/bilinear_wrap_texture_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler
// Bilinear RGBA8 texture sampler with repeat wrapping and a 64K-texel store.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream; in_tuser selects a texel write (0) or a
// sample (1). A write stores one RGBA8 texel at row*tex_width+column and gives
// no result; a write outside the configured size is dropped. A sample wraps
// u and v to their fractions, finds the four neighbor texels with repeat
// wrapping and returns one blended, rounded RGBA8 value on the out_ stream.
// A new request is taken only in the idle state, once the write or sample
// before it is through. A sample steps through locating the neighbors,
// forming row offsets and weights, the four neighbor reads one after another
// through the single port of the texel store, a drain for the last
// accumulation and the load of the output register. The result sits in an
// output register while new requests are accepted; a following sample
// waits only if that register is still occupied when it finishes. Set
// tex_width and tex_height over the cfg_ port while no request is in flight.
// Texels read before they are written return undefined data.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: tex_u[31:0], tex_v[63:32], texel_x[71:64],
  // texel_y[79:72], red_in[87:80], green_in[95:88], blue_in[103:96],
  // alpha_in[111:104]
  input  logic [111:0] in_tdata,
  // tuser: cmd
  input  logic         in_tuser,
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata from bit 0: red_out[7:0], green_out[15:8], blue_out[23:16],
  // alpha_out[31:24]
  output logic [31:0]  out_tdata,
  // Configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  import bwts_pkg::*;

  logic [SIZE_W-1:0] tex_width_r, tex_height_r;
  logic [SIZE_W-1:0] cfg_size;
  logic              cfg_wr;
  logic              cfg_sel;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  // Clamp a written size into 1..256
  always_comb begin
    cfg_size = cfg_pwdata[SIZE_W-1:0];
    if (cfg_size == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_size > SIZE_W'(SIZE_MAX)) begin
      cfg_size = SIZE_W'(SIZE_MAX);
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_pready = 1'b1;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SIZE_W'(1);
      tex_height_r <= SIZE_W'(1);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_WIDTH:  tex_width_r  <= cfg_size;
        REG_HEIGHT: tex_height_r <= cfg_size;
        default:    tex_width_r  <= tex_width_r;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (cfg_sel)
      REG_WIDTH:  cfg_prdata = {{(32 - SIZE_W){1'b0}}, tex_width_r};
      REG_HEIGHT: cfg_prdata = {{(32 - SIZE_W){1'b0}}, tex_height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  bwts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bwts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .tex_width  (tex_width_r),
    .tex_height (tex_height_r),
    .in_data    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule
